### hdl/euler_angles_to_rotation_matrix_macros.svh
// Assertion macros used by the top-level RTL file of the Euler angle rotation block.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define EATRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication into the following cycle, checked outside reset.
`define EATRM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/eatrm_pkg.sv
// Types, constants and arithmetic helpers of the Euler angle rotation block.
`default_nettype none
package eatrm_pkg;

  localparam int ANG_W = 32;
  localparam int N_STEP = 4;
  // Latency of one sine/cosine lane and of the whole block, in cycles.
  localparam int SC_LAT = 5 + 3 * N_STEP;
  localparam int LAT = SC_LAT + 3;

  typedef logic signed [31:0] trig_t;
  typedef logic [30:0] q30u_t;
  typedef logic [5:0] div_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } car_t;

  localparam logic [40:0] RAD_SCALE = 41'd1228166276394;
  localparam q30u_t       Q30_ONE = 31'h4000_0000;
  localparam logic [22:0] DEG45 = 23'd2949120;
  localparam logic [22:0] DEG90 = 23'd5898240;
  localparam logic [16:0] WRAP_OFS = 17'd33120;
  localparam logic [13:0] RECIP360 = 14'd11651;
  localparam logic [8:0]  DEG_FULL = 9'd360;
  localparam logic [8:0]  DEG_Q1 = 9'd90;
  localparam logic [8:0]  DEG_Q2 = 9'd180;
  localparam logic [8:0]  DEG_Q3 = 9'd270;

  // The sine series has one step fewer; its last entries are placeholders.
  localparam div_t SIN_DIV [N_STEP] = '{6'd42, 6'd20, 6'd6, 6'd1};
  localparam div_t COS_DIV [N_STEP] = '{6'd56, 6'd30, 6'd12, 6'd2};
  localparam logic [31:0] SIN_RECIP [N_STEP] = '{
    32'(64'd4294967296 / 64'd42), 32'(64'd4294967296 / 64'd20),
    32'(64'd4294967296 / 64'd6), 32'd0};
  localparam logic [31:0] COS_RECIP [N_STEP] = '{
    32'(64'd4294967296 / 64'd56), 32'(64'd4294967296 / 64'd30),
    32'(64'd4294967296 / 64'd12), 32'(64'd4294967296 / 64'd2)};

  // The reciprocal estimate is at most one low; one compare fixes it.
  function automatic q30u_t div_fix(q30u_t q0, q30u_t p, div_t d);
    logic [36:0] prod;
    logic [36:0] rem;
    prod = 37'(q0) * 37'(d);
    rem = 37'(p) - prod;
    return (rem >= 37'(d)) ? q30u_t'(q0 + 31'd1) : q0;
  endfunction

  // Sign-magnitude Q30 product, rounded half away from zero.
  function automatic trig_t mul30(trig_t a, trig_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] m;
    logic        neg;
    neg = a[31] ^ b[31];
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    m = 64'(ma) * 64'(mb) + 64'd536870912;
    return neg ? -trig_t'(m[61:30]) : trig_t'(m[61:30]);
  endfunction

endpackage
`default_nettype wire

### hdl/eatrm_if.sv
// Handshake interfaces for the angle and rotation basis words.
`default_nettype none
interface eatrm_in_if;
  import eatrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] yaw_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface eatrm_out_if #(parameter int OUT_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] fwd_x;
  logic signed [OUT_WIDTH-1:0] fwd_y;
  logic signed [OUT_WIDTH-1:0] fwd_z;
  logic signed [OUT_WIDTH-1:0] left_x;
  logic signed [OUT_WIDTH-1:0] left_y;
  logic signed [OUT_WIDTH-1:0] left_z;
  logic signed [OUT_WIDTH-1:0] up_x;
  logic signed [OUT_WIDTH-1:0] up_y;
  logic signed [OUT_WIDTH-1:0] up_z;
  modport source (output valid, fwd_x, fwd_y, fwd_z, left_x, left_y, left_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, fwd_x, fwd_y, fwd_z, left_x, left_y, left_z,
                up_x, up_y, up_z, output ready);
endinterface
`default_nettype wire

### hdl/eatrm_sincos.sv
// Pipelined sine and cosine of one Q16.16 degree angle, Q30 results.
`default_nettype none
module eatrm_sincos (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [31:0]   angle_i,
  output eatrm_pkg::trig_t     sin_o,
  output eatrm_pkg::trig_t     cos_o
);
  import eatrm_pkg::*;

  // Wrap: the integer degrees are offset positive, then reduced mod 360.
  logic [17:0] hsum;
  logic [16:0] hb_d, hb_q;
  logic [30:0] qprod;
  logic [15:0] frac_q;
  logic [7:0]  qt_q;

  assign hsum = 18'($signed(angle_i[31:16])) + 18'(WRAP_OFS);
  assign hb_d = hsum[16:0];
  assign qprod = 31'(hb_d) * 31'(RECIP360);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hb_q <= hb_d;
      frac_q <= angle_i[15:0];
      qt_q <= qprod[29:22];
    end
  end

  logic signed [17:0] rem_raw;
  logic [8:0]  rem;
  logic [1:0]  quad_d, quad_q;
  logic [8:0]  rdeg;
  logic [22:0] rfull;
  logic        swap_d, swap_q;
  logic [22:0] r_d, r_q;

  always_comb begin
    rem_raw = signed'(18'(hb_q) - 18'(qt_q) * 18'(DEG_FULL));
    if (rem_raw[17]) begin
      rem = 9'(rem_raw + 18'(DEG_FULL));
    end else begin
      rem = rem_raw[8:0];
    end
    if (rem >= DEG_Q3) begin
      quad_d = 2'd3;
      rdeg = rem - DEG_Q3;
    end else if (rem >= DEG_Q2) begin
      quad_d = 2'd2;
      rdeg = rem - DEG_Q2;
    end else if (rem >= DEG_Q1) begin
      quad_d = 2'd1;
      rdeg = rem - DEG_Q1;
    end else begin
      quad_d = 2'd0;
      rdeg = rem;
    end
    rfull = {rdeg[6:0], frac_q};
    swap_d = rfull > DEG45;
    r_d = swap_d ? (DEG90 - rfull) : rfull;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      quad_q <= quad_d;
      swap_q <= swap_d;
    end
  end

  // Degrees to radians, then the square of the radian value.
  logic [63:0] xprod;
  logic [29:0] x_q;
  logic [1:0]  quad_x_q;
  logic        swap_x_q;
  logic [59:0] x2prod;
  car_t        car_x2_q;

  assign xprod = 64'(r_q) * 64'(RAD_SCALE) + 64'h8000_0000;
  assign x2prod = 60'(x_q) * 60'(x_q) + 60'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= xprod[61:32];
      quad_x_q <= quad_q;
      swap_x_q <= swap_q;
      car_x2_q <= '{x: x_q, x2: x2prod[59:30], quad: quad_x_q, swap: swap_x_q};
    end
  end

  // Each series step: product, reciprocal estimate, fix and subtract.
  car_t  car_p_q [N_STEP];
  car_t  car_m_q [N_STEP];
  car_t  car_c_q [N_STEP];
  q30u_t ps_q [N_STEP];
  q30u_t pc_q [N_STEP];
  q30u_t pm_s_q [N_STEP];
  q30u_t pm_c_q [N_STEP];
  q30u_t qs_q [N_STEP];
  q30u_t qc_q [N_STEP];
  q30u_t ts_q [N_STEP];
  q30u_t tc_q [N_STEP];

  for (genvar j = 0; j < N_STEP; j++) begin : g_step
    car_t        cin;
    q30u_t       ps_d;
    q30u_t       pc_d;
    logic [62:0] mq_s;
    logic [62:0] mq_c;

    if (j == 0) begin : g_first
      assign cin = car_x2_q;
      assign ps_d = 31'(car_x2_q.x2);
      assign pc_d = 31'(car_x2_q.x2);
    end else begin : g_next
      logic [61:0] mp_s;
      logic [61:0] mp_c;
      assign cin = car_c_q[j-1];
      // The last sine step multiplies by x and closes the series.
      if (j == N_STEP - 1) begin : g_sin_last
        assign mp_s = 62'(car_c_q[j-1].x) * 62'(ts_q[j-1]);
      end else begin : g_sin_mid
        assign mp_s = 62'(car_c_q[j-1].x2) * 62'(ts_q[j-1]);
      end
      assign mp_c = 62'(car_c_q[j-1].x2) * 62'(tc_q[j-1]);
      assign ps_d = mp_s[60:30];
      assign pc_d = mp_c[60:30];
    end

    assign mq_s = 63'(ps_q[j]) * 63'(SIN_RECIP[j]);
    assign mq_c = 63'(pc_q[j]) * 63'(COS_RECIP[j]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        car_p_q[j] <= cin;
        ps_q[j] <= ps_d;
        pc_q[j] <= pc_d;
        car_m_q[j] <= car_p_q[j];
        pm_s_q[j] <= ps_q[j];
        pm_c_q[j] <= pc_q[j];
        qs_q[j] <= mq_s[62:32];
        qc_q[j] <= mq_c[62:32];
        car_c_q[j] <= car_m_q[j];
        tc_q[j] <= Q30_ONE - div_fix(qc_q[j], pm_c_q[j], COS_DIV[j]);
      end
    end

    if (j == N_STEP - 1) begin : g_sin_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[j] <= pm_s_q[j];
        end
      end
    end else begin : g_sin_sub
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[j] <= Q30_ONE - div_fix(qs_q[j], pm_s_q[j], SIN_DIV[j]);
        end
      end
    end
  end

  // Octant swap and quadrant signs.
  trig_t s_val, c_val, sin_d, cos_d, sin_q, cos_q;
  car_t  car_end;

  always_comb begin
    car_end = car_c_q[N_STEP-1];
    if (car_end.swap) begin
      s_val = trig_t'({1'b0, tc_q[N_STEP-1]});
      c_val = trig_t'({1'b0, ts_q[N_STEP-1]});
    end else begin
      s_val = trig_t'({1'b0, ts_q[N_STEP-1]});
      c_val = trig_t'({1'b0, tc_q[N_STEP-1]});
    end
    case (car_end.quad)
      2'd0: begin
        sin_d = s_val;
        cos_d = c_val;
      end
      2'd1: begin
        sin_d = c_val;
        cos_d = -s_val;
      end
      2'd2: begin
        sin_d = -s_val;
        cos_d = -c_val;
      end
      default: begin
        sin_d = -c_val;
        cos_d = s_val;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

### hdl/euler_angles_to_rotation_matrix.sv
// Top level: yaw, pitch and roll angles to forward, left and up basis vectors.
//
// The input channel in_i takes one word of three signed Q16.16 degree angles
// (any value, wrapped modulo 360). The output channel out_o returns one word
// of nine signed Q1.(OUT_WIDTH-1) entries of the Z-Y-X rotation: forward,
// left and up basis vectors, with X forward, Y left and Z up.
// Both channels move a word when valid and ready are high at a clock edge.
// One word is taken every cycle while out_o does not stall: three
// sine/cosine lanes of 17 stages feed two product stages and a rounding
// stage, each with at most one multiplier level.
// When out_o stalls, the whole pipeline holds and in_i.ready drops, except
// that a word is still taken whenever the output register is empty.
// Reset clears all valid bits; data registers are not reset. There is no
// stored state between words.
`default_nettype none
`include "euler_angles_to_rotation_matrix_macros.svh"
module euler_angles_to_rotation_matrix #(
  parameter int OUT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  eatrm_in_if.sink       in_i,
  eatrm_out_if.source    out_o
);
  import eatrm_pkg::*;

  localparam int SH = 31 - OUT_WIDTH;
  localparam int SHP = (SH > 0) ? SH : 0;
  localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
  localparam logic [34:0] LIM = 35'd1 << (OUT_WIDTH - 1);

  logic           en;
  logic [LAT-1:0] valid_q;

  assign en = !valid_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_i.valid};
    end
  end

  trig_t sy, cy, sp, cp, sr, cr;

  eatrm_sincos u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.yaw_angle), .sin_o(sy), .cos_o(cy)
  );
  eatrm_sincos u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.pitch_angle), .sin_o(sp), .cos_o(cp)
  );
  eatrm_sincos u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(in_i.roll_angle), .sin_o(sr), .cos_o(cr)
  );

  // First products of two factors; the three-factor terms reuse some.
  trig_t cycp_q, sycp_q, spsr_q, crsy_q, cycr_q, sysp_q, srcp_q, sysr_q;
  trig_t cysp_q, srcy_q, cpcr_q, sp_q, cy_q, sr_q, cr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cycp_q <= mul30(cy, cp);
      sycp_q <= mul30(sy, cp);
      spsr_q <= mul30(sp, sr);
      crsy_q <= mul30(cr, sy);
      cycr_q <= mul30(cy, cr);
      sysp_q <= mul30(sy, sp);
      srcp_q <= mul30(sr, cp);
      sysr_q <= mul30(sy, sr);
      cysp_q <= mul30(cy, sp);
      srcy_q <= mul30(sr, cy);
      cpcr_q <= mul30(cp, cr);
      sp_q <= sp;
      cy_q <= cy;
      sr_q <= sr;
      cr_q <= cr;
    end
  end

  trig_t t3_q, t4_q, t6_q, t7_q;
  trig_t cycp2_q, sycp2_q, sp2_q, crsy2_q, cycr2_q, srcp2_q, sysr2_q, srcy2_q, cpcr2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q <= mul30(spsr_q, cy_q);
      t4_q <= mul30(sysp_q, sr_q);
      t6_q <= mul30(cysp_q, cr_q);
      t7_q <= mul30(sysp_q, cr_q);
      cycp2_q <= cycp_q;
      sycp2_q <= sycp_q;
      sp2_q <= sp_q;
      crsy2_q <= crsy_q;
      cycr2_q <= cycr_q;
      srcp2_q <= srcp_q;
      sysr2_q <= sysr_q;
      srcy2_q <= srcy_q;
      cpcr2_q <= cpcr_q;
    end
  end

  function automatic logic signed [OUT_WIDTH-1:0] to_out(logic signed [33:0] v);
    logic [34:0] mag;
    logic [34:0] m;
    mag = v[33] ? 35'(-v) : 35'(v);
    if (SH > 0) begin
      m = (mag + (35'd1 << RND_SH)) >> SHP;
    end else if (SH == 0) begin
      m = mag;
    end else begin
      m = mag << 1;
    end
    if (v[33]) begin
      if (m > LIM) begin
        m = LIM;
      end
      return OUT_WIDTH'(35'd0 - m);
    end
    if (m > LIM - 35'd1) begin
      m = LIM - 35'd1;
    end
    return OUT_WIDTH'(m);
  endfunction

  logic signed [33:0] v_d [9];
  logic signed [OUT_WIDTH-1:0] res_q [9];

  always_comb begin
    v_d[0] = 34'(cycp2_q);
    v_d[1] = 34'(sycp2_q);
    v_d[2] = 34'sd0 - 34'(sp2_q);
    v_d[3] = 34'(t3_q) - 34'(crsy2_q);
    v_d[4] = 34'(cycr2_q) + 34'(t4_q);
    v_d[5] = 34'(srcp2_q);
    v_d[6] = 34'(sysr2_q) + 34'(t6_q);
    v_d[7] = 34'(t7_q) - 34'(srcy2_q);
    v_d[8] = 34'(cpcr2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        res_q[i] <= to_out(v_d[i]);
      end
    end
  end

  assign out_o.valid = valid_q[LAT-1];
  assign out_o.fwd_x = res_q[0];
  assign out_o.fwd_y = res_q[1];
  assign out_o.fwd_z = res_q[2];
  assign out_o.left_x = res_q[3];
  assign out_o.left_y = res_q[4];
  assign out_o.left_z = res_q[5];
  assign out_o.up_x = res_q[6];
  assign out_o.up_y = res_q[7];
  assign out_o.up_z = res_q[8];

  `EATRM_ASSERT(a_empty_takes, !valid_q[LAT-1] |-> in_i.ready, "input blocked with empty output")
  `EATRM_ASSERT_NEXT(a_stall_holds, valid_q[LAT-1] && !out_o.ready, $stable(valid_q), "pipeline moved during stall")
  `EATRM_ASSERT_NEXT(a_accept_enters, in_i.valid && in_i.ready, valid_q[0], "accepted word lost at entry")

endmodule
`default_nettype wire
